### src/size_class_pool_allocator_assert.svh
// Assertion macros for the pool allocator.
// Used by the top level only; no other dependencies.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define SCPA_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SCPA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

### src/scpa_pkg.sv
// Shared types and codes of the pool allocator.
// No dependencies.
`default_nettype none
package scpa_pkg;
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_PASSTHROUGH = 2'd1,
      ST_ZERO_SIZE   = 2'd2,
      ST_OUT_OF_BLKS = 2'd3
   } status_type;

   typedef struct packed {
      logic        command;
      logic [15:0] request_size;
      logic [19:0] unit_address;
   } req_type;

   typedef struct packed {
      logic [19:0] granted_address;
      status_type  status;
   } rsp_type;
endpackage
`default_nettype wire

### src/size_class_pool_allocator.sv
// Top level of the size-class pool allocator.
// Depends on scpa_pkg and size_class_pool_allocator_assert.svh.
`default_nettype none
// One request is handled at a time. The size check is made in S_DEC, and a
// rejected request goes from there straight to S_RSP. A release passes through
// S_HEAD, which writes the link memory write port and the head table, and a pop
// of a non-empty list passes through S_HEAD, S_RDLNK and S_POP. Carving a new
// block in S_CARVE writes one link a cycle. A result waits in an output register
// until taken, and the next request is accepted in the cycle after that.
`include "size_class_pool_allocator_assert.svh"
module size_class_pool_allocator
   import scpa_pkg::*;
#(
   parameter int NUM_CLASSES = 64,
   parameter int MIN_UNIT    = 16,
   parameter int MAX_UNIT    = 1024,
   parameter int BLOCK_BYTES = 16384,
   parameter int MAX_BLOCKS  = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [6:0] csr_data
);
   localparam int LINK_DEPTH = (MAX_BLOCKS * BLOCK_BYTES) / MIN_UNIT + 1;
   localparam int LW = $clog2(LINK_DEPTH);
   localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int BW = $clog2(MAX_BLOCKS + 1);
   localparam int AW = $clog2(MAX_BLOCKS * BLOCK_BYTES + 1);
   localparam int UW = $clog2(BLOCK_BYTES + 1);
   localparam int MAXU = (MAX_UNIT < NUM_CLASSES * MIN_UNIT) ? MAX_UNIT
                                                             : NUM_CLASSES * MIN_UNIT;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DEC   = 7'b0000010,
      S_HEAD  = 7'b0000100,
      S_RDLNK = 7'b0001000,
      S_POP   = 7'b0010000,
      S_CARVE = 7'b0100000,
      S_RSP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff;
   logic [6:0] limit_ff;
   logic [BW-1:0] used_ff;
   logic [CW-1:0] cls_ff;
   logic [AW:0] head_ff;           // valid bit and address of the selected head
   logic [NUM_CLASSES-1:0] hvalid_ff;
   logic [AW-1:0] hmem [NUM_CLASSES];
   logic [AW:0]   lmem [LINK_DEPTH];
   logic [AW:0]   lrd_ff;
   logic [UW-1:0] usize_ff;
   logic [AW-1:0] addr_ff;        // walking address during carving
   logic [AW-1:0] end_ff;         // first byte past the block being carved

   logic [15:0] sm1;
   assign sm1 = req_ff.request_size - 16'd1;

   // Block limit: the CSR limit capped at MAX_BLOCKS. A unit fits if usize <= BLOCK_BYTES.
   logic [6:0] lim;
   assign lim = (limit_ff < 7'(MAX_BLOCKS)) || (MAX_BLOCKS > 127) ? limit_ff
                                                                   : 7'(MAX_BLOCKS);

   logic [AW-1:0] next_a;
   assign next_a = addr_ff + AW'(usize_ff);

   // The unit at addr_ff is the last one when the unit after it would run past
   // the end of the block.
   logic last_unit;
   assign last_unit = ({1'b0, next_a} + (AW+1)'(usize_ff)) > {1'b0, end_ff};

   logic we;
   logic [LW-1:0] wa;
   logic [AW:0] wd;
   logic [LW-1:0] ra;
   logic hwe;
   logic [AW:0] hwd;

   always_comb begin
      state_in = state_ff;
      we = 1'b0; wa = '0; wd = '0; hwe = 1'b0; hwd = '0;
      ra = LW'(head_ff[AW-1:0] / AW'(MIN_UNIT));
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_DEC;
         S_DEC: state_in = (req_ff.request_size == 16'd0 ||
                            32'(req_ff.request_size) > MAXU) ? S_RSP : S_HEAD;
         S_HEAD: begin
            if (req_ff.command == CMD_RELEASE) begin
               if (32'(req_ff.unit_address) / MIN_UNIT < LINK_DEPTH) begin
                  we = 1'b1;
                  wa = LW'(32'(req_ff.unit_address) / MIN_UNIT);
                  wd = head_ff;
                  hwe = 1'b1;
                  hwd = {1'b1, AW'(req_ff.unit_address)};
               end
               state_in = S_RSP;
            end else if (head_ff[AW]) state_in = S_RDLNK;
            else if (32'(used_ff) >= 32'(lim) || 32'(usize_ff) > BLOCK_BYTES)
               state_in = S_RSP;
            else state_in = S_CARVE;
         end
         S_RDLNK: state_in = S_POP;
         S_POP: begin
            hwe = 1'b1; hwd = lrd_ff; state_in = S_RSP;
         end
         S_CARVE: begin
            we = 1'b1;
            wa = LW'(addr_ff / AW'(MIN_UNIT));
            wd = last_unit ? '0 : {1'b1, next_a};
            if (last_unit) begin
               hwe = 1'b1;
               hwd = (addr_ff == AW'(32'(used_ff) * BLOCK_BYTES)) ? '0
                     : {1'b1, AW'(AW'(32'(used_ff) * BLOCK_BYTES) + AW'(usize_ff))};
               state_in = S_RSP;
            end
         end
         S_RSP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) lmem[wa] <= wd;
      lrd_ff <= lmem[ra];
      if (hwe) hmem[cls_ff] <= hwd[AW-1:0];
      head_ff <= {hvalid_ff[cls_ff], hmem[cls_ff]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         limit_ff  <= 7'd64;
         used_ff   <= '0;
         hvalid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) limit_ff <= csr_data;
         if (hwe) hvalid_ff[cls_ff] <= hwd[AW];
         if (state_ff == S_CARVE && last_unit) used_ff <= used_ff + BW'(1);
      end
   end

   // Payload registers. The class is taken with the beat so that the head
   // table read is ready by the time the request reaches S_HEAD.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            req_ff <= req_data;
            cls_ff <= CW'((req_data.request_size - 16'd1) / 16'(MIN_UNIT));
         end
         S_DEC: begin
            usize_ff <= UW'((32'(sm1 / 16'(MIN_UNIT)) + 1) * MIN_UNIT);
            rsp_ff.granted_address <= '0;
            rsp_ff.status <= (req_ff.request_size == 16'd0) ? ST_ZERO_SIZE
                                                             : ST_PASSTHROUGH;
         end
         S_HEAD: begin
            rsp_ff.status <= ST_OK;
            addr_ff <= AW'(32'(used_ff) * BLOCK_BYTES);
            end_ff  <= AW'(32'(used_ff) * BLOCK_BYTES + BLOCK_BYTES);
            if (req_ff.command == CMD_ALLOC && !head_ff[AW] &&
                (32'(used_ff) >= 32'(lim) || 32'(usize_ff) > BLOCK_BYTES))
               rsp_ff.status <= ST_OUT_OF_BLKS;
            if (req_ff.command == CMD_ALLOC && head_ff[AW])
               rsp_ff.granted_address <= 20'(head_ff[AW-1:0]);
            else if (req_ff.command == CMD_ALLOC &&
                     !(32'(used_ff) >= 32'(lim) || 32'(usize_ff) > BLOCK_BYTES))
               rsp_ff.granted_address <= 20'(32'(used_ff) * BLOCK_BYTES);
         end
         S_CARVE: addr_ff <= next_a;
         default: ;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   `SCPA_ASSERT_IMP(a_rsp_not_idle, clock, reset, rsp_valid, !req_ready)
   `SCPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_data))
   `SCPA_ASSERT_IMP(a_used_bound, clock, reset, 1'b1, 32'(used_ff) <= MAX_BLOCKS)
endmodule
`default_nettype wire
